FILE: design/xxtea_pkg.sv
package xxtea_pkg;

  localparam int BLOCK_WORDS = 8;
  localparam int WIDX        = $clog2(BLOCK_WORDS);
  localparam int ROUNDS      = 6 + 52 / BLOCK_WORDS;
  localparam int RW          = $clog2(ROUNDS);
  localparam int QDEPTH      = 4;
  localparam int QPW         = $clog2(QDEPTH);
  localparam logic [31:0] DELTA = 32'h9e3779b9;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t data;
  } qhead_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_EMIT
  } eng_state_t;

  function automatic logic [31:0] mix(
    input logic [31:0] y,
    input logic [31:0] z,
    input logic [31:0] sum,
    input logic [31:0] k
  );
    logic [31:0] a;
    logic [31:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (k ^ z);
    return a ^ b;
  endfunction

endpackage

FILE: design/xxtea_block_encrypt_unit.sv
// channel   | valid      | stall      | payload
// ----------+------------+------------+------------------------------------
// input     | in_valid   | in_stall   | in_plain_word
// output    | out_valid  | out_stall  | out_cipher_word, out_block_end
// config    | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A block is loaded, run for R rounds of N MX updates each (one MX update per
// cycle on a rotating word register) and then emitted, with N=8 and R=12.
// All round steps share the single MX adder path.
// A four-entry queue takes input words while the engine runs or emits.
// Reset (rst_n low, synchronous) clears keys, counters and valid flags.
// Output is registered; a stall holds the engine in emit without losing words.
module xxtea_block_encrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_plain_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cipher_word,
  output logic        out_block_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  logic [3:0][31:0]   key_r;
  xxtea_pkg::qhead_t  q_head;
  logic               q_pop;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_KEY0: key_r[0] <= pwdata;
        REG_KEY1: key_r[1] <= pwdata;
        REG_KEY2: key_r[2] <= pwdata;
        REG_KEY3: key_r[3] <= pwdata;
        default:  key_r    <= key_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KEY0: prdata = key_r[0];
      REG_KEY1: prdata = key_r[1];
      REG_KEY2: prdata = key_r[2];
      REG_KEY3: prdata = key_r[3];
      default:  prdata = '0;
    endcase
  end

  xxtea_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_plain_word (in_plain_word),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  xxtea_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .key             (key_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_word (out_cipher_word),
    .out_block_end   (out_block_end)
  );

endmodule

FILE: design/xxtea_front.sv
module xxtea_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_plain_word,
  output xxtea_pkg::qhead_t   q_head,
  input  logic                q_pop
);

  xxtea_pkg::qent_t                 mem_r [xxtea_pkg::QDEPTH];
  logic [xxtea_pkg::QPW-1:0]        wr_ptr_r;
  logic [xxtea_pkg::QPW-1:0]        rd_ptr_r;
  logic [xxtea_pkg::QPW:0]          fill_r;
  logic [xxtea_pkg::WIDX-1:0]       cnt_r;
  logic                             push;
  logic                             pop;
  logic                             last_word;

  assign in_stall  = (fill_r == (xxtea_pkg::QPW + 1)'(xxtea_pkg::QDEPTH));
  assign push      = in_valid && !in_stall;
  assign pop       = q_pop && (fill_r != '0);
  assign last_word = (cnt_r == xxtea_pkg::WIDX'(xxtea_pkg::BLOCK_WORDS - 1));

  assign q_head.valid = (fill_r != '0);
  assign q_head.data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{word: in_plain_word, last: last_word};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
        cnt_r    <= last_word ? '0 : cnt_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

FILE: design/xxtea_back.sv
module xxtea_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xxtea_pkg::qhead_t       q_head,
  output logic                    q_pop,
  input  logic [3:0][31:0]        key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             out_cipher_word,
  output logic                    out_block_end
);

  localparam int N = xxtea_pkg::BLOCK_WORDS;

  xxtea_pkg::eng_state_t          state_r, state_nxt;
  logic [31:0]                    sh_r [N];
  logic [31:0]                    z_r;
  logic [31:0]                    sum_r;
  logic [xxtea_pkg::WIDX-1:0]     p_r;
  logic [xxtea_pkg::RW-1:0]       rnd_r;
  logic                           out_valid_r;
  logic [31:0]                    out_word_r;
  logic                           out_end_r;

  logic                           load_in;
  logic                           run_step;
  logic                           emit;
  logic                           p_last;
  logic                           r_last;
  logic [7:0]                     p_ext;
  logic [1:0]                     ksel;
  logic [31:0]                    new_word;
  logic [31:0]                    shift_in;

  assign p_last   = (p_r == xxtea_pkg::WIDX'(N - 1));
  assign r_last   = (rnd_r == xxtea_pkg::RW'(xxtea_pkg::ROUNDS - 1));
  assign p_ext    = 8'(p_r);
  assign ksel     = p_ext[1:0] ^ sum_r[3:2];
  assign new_word = sh_r[0] + xxtea_pkg::mix(sh_r[1], z_r, sum_r, key[ksel]);

  always_comb begin
    state_nxt = state_r;
    load_in   = 1'b0;
    run_step  = 1'b0;
    emit      = 1'b0;
    shift_in  = sh_r[0];
    unique case (state_r)
      xxtea_pkg::ST_LOAD: begin
        load_in  = q_head.valid;
        shift_in = q_head.data.word;
        if (load_in && q_head.data.last) begin
          state_nxt = xxtea_pkg::ST_RUN;
        end
      end
      xxtea_pkg::ST_RUN: begin
        run_step = 1'b1;
        shift_in = new_word;
        if (p_last && r_last) begin
          state_nxt = xxtea_pkg::ST_EMIT;
        end
      end
      xxtea_pkg::ST_EMIT: begin
        emit     = !out_valid_r || !out_stall;
        shift_in = sh_r[0];
        if (emit && p_last) begin
          state_nxt = xxtea_pkg::ST_LOAD;
        end
      end
      default: state_nxt = xxtea_pkg::ST_LOAD;
    endcase
  end

  assign q_pop = load_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xxtea_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in || run_step || emit) begin
      for (int i = 0; i < N - 1; i++) begin
        sh_r[i] <= sh_r[i + 1];
      end
      sh_r[N - 1] <= shift_in;
    end
    if (emit) begin
      out_word_r <= sh_r[0];
      out_end_r  <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r         <= '0;
      sum_r       <= '0;
      p_r         <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_in) begin
        z_r   <= q_head.data.word;
        sum_r <= xxtea_pkg::DELTA;
        p_r   <= '0;
        rnd_r <= '0;
      end
      if (run_step) begin
        z_r <= new_word;
        if (p_last) begin
          p_r   <= '0;
          sum_r <= sum_r + xxtea_pkg::DELTA;
          rnd_r <= rnd_r + 1'b1;
        end else begin
          p_r <= p_r + 1'b1;
        end
      end
      if (emit) begin
        p_r <= p_last ? '0 : p_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_word = out_word_r;
  assign out_block_end   = out_end_r;

  a_pop_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == xxtea_pkg::ST_LOAD)
    else $error("queue popped outside load");

  a_run_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xxtea_pkg::ST_RUN && $past(state_r) == xxtea_pkg::ST_LOAD)
      |-> $past(q_pop && q_head.data.last))
    else $error("encryption started without a full block");

  a_emit_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && p_last) |=> (out_valid && out_block_end
      && state_r == xxtea_pkg::ST_LOAD))
    else $error("final word of block not marked");

  a_run_no_output_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xxtea_pkg::ST_RUN |=> !(emit && state_r == xxtea_pkg::ST_LOAD))
    else $error("engine left run without emitting");

endmodule
